>>> rtl/rpc_pkg.sv
// shared types, constants and helper functions of the ramdac palette and cursor pixel path
`default_nettype none

package rpc_pkg;

	localparam int unsigned PAL_AW      = 8;
	localparam int unsigned PAL_DEPTH   = 256;
	localparam int unsigned ROW_AW      = 5;
	localparam int unsigned CURSOR_ROWS = 32;
	localparam int unsigned CFG_DW      = 11;

	localparam logic [12:0] MAX_WIDTH        = 13'd1024;
	localparam logic [23:0] RGB_WHITE        = 24'hFF_FFFF;
	localparam logic [7:0]  PAL_WHITE_ENTRY  = 8'hFF;
	localparam logic [31:0] MISC_READ_SET    = 32'h0200_0000;
	localparam logic [15:0] CURSOR_OFF       = 16'hF000;
	localparam logic [10:0] ACTIVE_WIDTH_RST = 11'd1024;

	typedef enum logic [3:0] {
		MODE_SET_INDEX  = 4'd0,
		MODE_WR_PAL     = 4'd1,
		MODE_WR_OVL     = 4'd2,
		MODE_RD_PAL     = 4'd3,
		MODE_SET_CURSOR = 4'd4,
		MODE_WR_MASK    = 4'd5,
		MODE_WR_BITS    = 4'd6,
		MODE_WR_MISC    = 4'd7,
		MODE_RD_MISC    = 4'd8,
		MODE_PIXEL      = 4'd9
	} mode_t;

	typedef enum logic [1:0] {
		PH_RED   = 2'd0,
		PH_GREEN = 2'd1,
		PH_BLUE  = 2'd2,
		PH_NONE  = 2'd3
	} phase_t;

	typedef enum logic [0:0] {
		CFG_ACTIVE_WIDTH = 1'b0,
		CFG_DIRECT_EN    = 1'b1
	} cfg_index_t;

	typedef struct packed {
		logic [3:0]  mode;
		logic [31:0] bus_data;
		logic [4:0]  row_index;
		logic [9:0]  pixel_x;
		logic [9:0]  pixel_y;
		logic [7:0]  color_index;
		logic [1:0]  plane_select;
		logic [7:0]  direct_red;
		logic [7:0]  direct_green;
		logic [7:0]  direct_blue;
	} rpc_in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [23:0] pixel_rgb;
	} rpc_out_t;

	// replace one color component of a palette word
	function automatic logic [23:0] merge_comp(input logic [23:0] word, input phase_t ph,
			input logic [7:0] comp);
		logic [23:0] res;
		res = word;
		unique case (ph)
			PH_RED:   res[23:16] = comp;
			PH_GREEN: res[15:8]  = comp;
			PH_BLUE:  res[7:0]   = comp;
			PH_NONE:  res        = word;
		endcase
		return res;
	endfunction

	// pick one color component, zero in the unused phase
	function automatic logic [7:0] pick_comp(input logic [23:0] word, input phase_t ph);
		logic [7:0] res;
		res = '0;
		unique case (ph)
			PH_RED:   res = word[23:16];
			PH_GREEN: res = word[15:8];
			PH_BLUE:  res = word[7:0];
			PH_NONE:  res = '0;
		endcase
		return res;
	endfunction

endpackage

`default_nettype wire

>>> rtl/rpc_pal_ram.sv
// color palette memory with per-entry valid bits and write-to-read forwarding
`default_nettype none

module rpc_pal_ram (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [rpc_pkg::PAL_AW-1:0] rd_addr,
	output logic [23:0]                rd_data,
	input  logic                       wr_en,
	input  logic [rpc_pkg::PAL_AW-1:0] wr_addr,
	input  logic [23:0]                wr_data
);
	import rpc_pkg::*;

	logic [23:0]          mem [PAL_DEPTH];
	logic [PAL_DEPTH-1:0] vld_q;
	logic [23:0]          mem_rd_q;
	logic [23:0]          fwd_data_q;
	logic                 vld_rd_q;
	logic                 fwd_q;
	logic                 white_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			fwd_data_q <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
			fwd_q    <= 1'b0;
			white_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q <= vld_q[rd_addr];
				fwd_q    <= wr_en && (wr_addr == rd_addr);
				white_q  <= (rd_addr == PAL_WHITE_ENTRY);
			end
		end
	end

	// unwritten entries read as their reset color
	assign rd_data = fwd_q    ? fwd_data_q :
	                 vld_rd_q ? mem_rd_q   :
	                 white_q  ? RGB_WHITE  : '0;

endmodule

`default_nettype wire

>>> rtl/rpc_row_ram.sv
// cursor row memory, 32 rows of 32 bits, rows read as zero until written
`default_nettype none

module rpc_row_ram (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       rd_en,
	input  logic [rpc_pkg::ROW_AW-1:0] rd_addr,
	output logic [31:0]                rd_data,
	input  logic                       wr_en,
	input  logic [rpc_pkg::ROW_AW-1:0] wr_addr,
	input  logic [31:0]                wr_data
);
	import rpc_pkg::*;

	logic [31:0]            mem [CURSOR_ROWS];
	logic [CURSOR_ROWS-1:0] vld_q;
	logic [31:0]            mem_rd_q;
	logic                   vld_rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			mem_rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				vld_rd_q <= vld_q[rd_addr];
			end
		end
	end

	assign rd_data = vld_rd_q ? mem_rd_q : '0;

endmodule

`default_nettype wire

>>> rtl/ramdac_palette_cursor_pixel_path_unit.sv
// top level of the ramdac palette and hardware cursor pixel path
//
//  channel  | signals                          | direction | transfer when
//  ---------+----------------------------------+-----------+------------------------
//  input    | in_valid, in_stall, in_data      | in        | in_valid && !in_stall
//  output   | out_valid, out_stall, out_data   | out       | out_valid && !out_stall
//  config   | cfg_we, cfg_index, cfg_data      | in        | cfg_we
//
//  one item per cycle sustained while out_stall is low; every item is registered in s1, then in the output register
//  stage s1 holds the registered palette and cursor row reads, the output register follows
//  palette component writes are read-modify-write: read at transfer, written as s1 moves on,
//  with forwarding in the palette memory when the next item reads the same entry
//  reset clears the memory valid bits only, no clearing pass; the block accepts items right after reset
//  in_stall rises only while s1 is full and the output register is held by out_stall
`default_nettype none

module ramdac_palette_cursor_pixel_path_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  rpc_pkg::rpc_in_t           in_data,
	output logic                       out_valid,
	input  logic                       out_stall,
	output rpc_pkg::rpc_out_t          out_data,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [rpc_pkg::CFG_DW-1:0] cfg_data
);
	import rpc_pkg::*;

	// configuration
	logic [10:0] active_width_q;
	logic        direct_en_q;

	// dac and cursor registers
	logic [7:0]  dac_ptr_q;
	phase_t      dac_phase_q;
	logic [7:0]  dac_ptr_d;
	phase_t      dac_phase_d;
	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [31:0] misc_q;
	logic [23:0] ovl_q [2];      // overlay entries used by the cursor colors

	// handshake
	logic accept;
	logic s1_free;
	logic s1_move;
	logic valid_s1;
	logic out_valid_q;
	rpc_out_t out_data_q;

	// cursor cover, worked out at transfer
	logic [16:0] dx;
	logic [16:0] dy;
	logic        hit_x;
	logic        hit_y;
	logic        clip_ok;

	// stage s1
	rpc_in_t     pay_s1;
	logic [7:0]  ptr_s1;
	phase_t      phase_s1;
	logic        cover_s1;
	logic [4:0]  col_s1;

	// memories
	logic [PAL_AW-1:0] pal_rd_addr;
	logic [23:0]       pal_rd_data;
	logic              pal_wr_en;
	logic [23:0]       pal_wr_data;
	logic [31:0]       mask_rd_data;
	logic [31:0]       bits_rd_data;
	logic              mask_wr_en;
	logic              bits_wr_en;

	// s1 result
	logic [23:0] base_rgb;
	logic [23:0] pix_rgb;
	logic        cursor_on;
	rpc_out_t    result;

	// ---------------------------------------------------------------- handshake
	assign s1_free  = !out_valid_q || !out_stall;
	assign s1_move  = valid_s1 && s1_free;
	assign in_stall = valid_s1 && !s1_free;
	assign accept   = in_valid && !in_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (s1_free) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free) begin
			out_data_q <= result;
		end
	end

	// ---------------------------------------------------------------- configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q <= ACTIVE_WIDTH_RST;
			direct_en_q    <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_ACTIVE_WIDTH) begin
				active_width_q <= cfg_data;
			end else begin
				direct_en_q <= cfg_data[0];
			end
		end
	end

	// ---------------------------------------------------------------- dac pointer and phase
	always_comb begin
		dac_ptr_d   = dac_ptr_q;
		dac_phase_d = dac_phase_q;
		if (accept) begin
			if (in_data.mode == MODE_SET_INDEX) begin
				dac_ptr_d   = in_data.bus_data[31:24];
				dac_phase_d = PH_RED;
			end else if (in_data.mode == MODE_WR_PAL || in_data.mode == MODE_WR_OVL ||
					in_data.mode == MODE_RD_PAL) begin
				// red, green, blue, then on to the next entry
				unique case (dac_phase_q)
					PH_RED:   dac_phase_d = PH_GREEN;
					PH_GREEN: dac_phase_d = PH_BLUE;
					PH_BLUE: begin
						dac_phase_d = PH_RED;
						dac_ptr_d   = dac_ptr_q + 8'd1;
					end
					PH_NONE:  dac_phase_d = PH_RED;
				endcase
			end
		end
	end

	// register-side state, updated at transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dac_ptr_q   <= '0;
			dac_phase_q <= PH_RED;
			cursor_x_q  <= CURSOR_OFF;
			cursor_y_q  <= CURSOR_OFF;
			misc_q      <= '0;
			ovl_q[0]    <= RGB_WHITE;
			ovl_q[1]    <= '0;
		end else begin
			dac_ptr_q   <= dac_ptr_d;
			dac_phase_q <= dac_phase_d;
			if (accept) begin
				if (in_data.mode == MODE_SET_CURSOR) begin
					cursor_x_q <= in_data.bus_data[31:16];
					cursor_y_q <= in_data.bus_data[15:0];
				end
				if (in_data.mode == MODE_WR_MISC) begin
					misc_q <= in_data.bus_data;
				end
				// only the two cursor color entries of the overlay are ever shown
				if (in_data.mode == MODE_WR_OVL && dac_ptr_q[1]) begin
					ovl_q[dac_ptr_q[0]] <= merge_comp(ovl_q[dac_ptr_q[0]], dac_phase_q,
						in_data.bus_data[31:24]);
				end
			end
		end
	end

	// ---------------------------------------------------------------- cursor cover
	assign dx      = {7'b0, in_data.pixel_x} - {1'b0, cursor_x_q};
	assign dy      = {7'b0, in_data.pixel_y} - {1'b0, cursor_y_q};
	assign hit_x   = !dx[16] && (dx[15:5] == '0);
	assign hit_y   = !dy[16] && (dy[15:5] == '0);
	assign clip_ok = ({1'b0, in_data.pixel_x} < active_width_q) &&
	                 ({3'b0, in_data.pixel_x} < MAX_WIDTH);

	always_ff @(posedge clk) begin
		if (accept) begin
			pay_s1   <= in_data;
			ptr_s1   <= dac_ptr_q;
			phase_s1 <= dac_phase_q;
			cover_s1 <= hit_x && hit_y && clip_ok;
			col_s1   <= ~dx[4:0];   // leftmost column is the msb
		end
	end

	// ---------------------------------------------------------------- memories
	assign pal_rd_addr = (in_data.mode == MODE_PIXEL) ? in_data.color_index : dac_ptr_q;
	assign pal_wr_en   = s1_move && (pay_s1.mode == MODE_WR_PAL) && (phase_s1 != PH_NONE);
	assign pal_wr_data = merge_comp(pal_rd_data, phase_s1, pay_s1.bus_data[31:24]);
	assign mask_wr_en  = accept && (in_data.mode == MODE_WR_MASK);
	assign bits_wr_en  = accept && (in_data.mode == MODE_WR_BITS);

	rpc_pal_ram u_pal_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (pal_rd_addr),
		.rd_data (pal_rd_data),
		.wr_en   (pal_wr_en),
		.wr_addr (ptr_s1),
		.wr_data (pal_wr_data)
	);

	rpc_row_ram u_mask_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (dy[ROW_AW-1:0]),
		.rd_data (mask_rd_data),
		.wr_en   (mask_wr_en),
		.wr_addr (in_data.row_index),
		.wr_data (in_data.bus_data)
	);

	rpc_row_ram u_bits_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (dy[ROW_AW-1:0]),
		.rd_data (bits_rd_data),
		.wr_en   (bits_wr_en),
		.wr_addr (in_data.row_index),
		.wr_data (in_data.bus_data)
	);

	// ---------------------------------------------------------------- s1 result
	assign base_rgb  = (direct_en_q && (pay_s1.plane_select != 2'b00)) ?
	                   {pay_s1.direct_red, pay_s1.direct_green, pay_s1.direct_blue} :
	                   pal_rd_data;
	assign cursor_on = cover_s1 && mask_rd_data[col_s1];
	assign pix_rgb   = !cursor_on ? base_rgb :
	                   bits_rd_data[col_s1] ? ovl_q[1] : ovl_q[0];

	always_comb begin
		result = '0;
		unique case (pay_s1.mode)
			MODE_RD_PAL:  result.read_data = {pick_comp(pal_rd_data, phase_s1), 24'b0};
			MODE_RD_MISC: result.read_data = misc_q | MISC_READ_SET;
			MODE_PIXEL:   result.pixel_rgb = pix_rgb;
			default:      result = '0;
		endcase
	end

	// ---------------------------------------------------------------- checks
	a_phase_never_none: assert property (@(posedge clk) disable iff (!arst_n)
		dac_phase_q != PH_NONE)
		else $error("dac phase reached the unused code");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while the pipeline had room");

	a_pal_write_on_move: assert property (@(posedge clk) disable iff (!arst_n)
		pal_wr_en |-> s1_move)
		else $error("palette written by an item that is not moving on");

	a_nonpixel_black: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && pay_s1.mode != MODE_PIXEL) |=> (out_data_q.pixel_rgb == '0))
		else $error("non-pixel item produced a pixel color");

endmodule

`default_nettype wire
